/* sv/fxa_pkg.sv */
// ----------------------------------------------------------------------------
// fxa_pkg
// Shared types and constants for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int WordW = 32;
  localparam int FracW = 8;
  localparam int NumW  = WordW + FracW;  // scaled dividend width
  localparam int QDepth = 2;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT  = 4'd4, OP_LT  = 4'd5, OP_GE  = 4'd6, OP_LE  = 4'd7,
    OP_EQ  = 4'd8, OP_NE  = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
  } op_t;

  // Item passed from the front to the back through the queue.
  typedef struct packed {
    op_t              op;
    logic             is_div;
    logic             div_zero;
    logic             neg;       // result sign for mul/div
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] mag_a;
    logic [WordW-1:0] mag_b;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic             flag;
    logic             status;
  } res_t;

endpackage

/* sv/fxa_front.sv */
// ----------------------------------------------------------------------------
// fxa_front
// Accepts requests, takes operand magnitudes and classifies the operation.
// ----------------------------------------------------------------------------
module fxa_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  in_req_type,
  input  logic signed [fxa_pkg::WordW-1:0] in_operand_a,
  input  logic signed [fxa_pkg::WordW-1:0] in_operand_b,
  output logic                        q_valid,
  input  logic                        q_ready,
  output fxa_pkg::item_t              q_item
);

  logic           v_r;
  fxa_pkg::item_t it_r;
  fxa_pkg::item_t it_nxt;

  assign in_ready = !v_r || q_ready;
  assign q_valid  = v_r;
  assign q_item   = it_r;

  // classify and take magnitudes
  always_comb begin
    it_nxt.op       = fxa_pkg::op_t'(in_req_type);
    it_nxt.is_div   = (in_req_type == fxa_pkg::OP_DIV);
    it_nxt.div_zero = (in_operand_b == '0);
    it_nxt.neg      = in_operand_a[fxa_pkg::WordW-1] ^ in_operand_b[fxa_pkg::WordW-1];
    it_nxt.a        = in_operand_a;
    it_nxt.b        = in_operand_b;
    it_nxt.mag_a    = in_operand_a[fxa_pkg::WordW-1] ? (-in_operand_a) : in_operand_a;
    it_nxt.mag_b    = in_operand_b[fxa_pkg::WordW-1] ? (-in_operand_b) : in_operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      it_r <= it_nxt;
    end
  end

endmodule

/* sv/fxa_queue.sv */
// ----------------------------------------------------------------------------
// fxa_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module fxa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  fxa_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output fxa_pkg::item_t rd_item
);

  localparam int PtrW = $clog2(fxa_pkg::QDepth);

  fxa_pkg::item_t mem_r [fxa_pkg::QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0]   cnt_r;
  logic            push, pop;

  assign wr_ready = (cnt_r != PtrW'(0) + (PtrW+1)'(fxa_pkg::QDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

/* sv/fxa_back.sv */
// ----------------------------------------------------------------------------
// fxa_back
// Execution pipeline: stage 0 simple ops and mul partial products,
// then one quotient bit per stage of a pipelined restoring divider.
// All items ride the full pipeline so results stay in order.
// ----------------------------------------------------------------------------
module fxa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  fxa_pkg::item_t q_item,
  output logic           out_valid,
  input  logic           out_ready,
  output fxa_pkg::res_t  out_res
);

  localparam int W  = fxa_pkg::WordW;
  localparam int NS = fxa_pkg::NumW;   // divider stages, one quotient bit each
  localparam int HW = W / 2;

  typedef struct packed {
    logic             valid;
    fxa_pkg::op_t     op;
    logic             neg;
    logic             dz;
    fxa_pkg::res_t    simple;     // result of non-mul/div ops
    logic [W-1:0]     d;          // divisor magnitude
    logic [NS-1:0]    num;        // dividend bits, shifted out MSB first
    logic [W:0]       rem;
    logic [NS-1:0]    quo;
    logic [2*W-1:0]   prod;       // mul product (accumulated at stage 1)
    logic [W-1:0]     pll, plh, phl, phh;
  } st_t;

  st_t st_r [NS+1];
  st_t s0_nxt;
  st_t sn_nxt [NS+1];
  logic adv;

  // whole pipeline moves when the last stage can drain
  assign adv     = !st_r[NS].valid || out_ready;
  assign q_ready = adv;
  assign out_valid = st_r[NS].valid;

  // stage 0: simple ops, 16x16 partial products of the magnitudes
  always_comb begin
    logic lt_ab, lt_ba;
    logic [W-1:0] a, b;
    a = q_item.a;
    b = q_item.b;
    lt_ab = $signed(a) < $signed(b);
    lt_ba = $signed(b) < $signed(a);
    s0_nxt = '0;
    s0_nxt.valid = q_valid;
    s0_nxt.op    = q_item.op;
    s0_nxt.neg   = q_item.neg;
    s0_nxt.dz    = q_item.is_div && q_item.div_zero;
    s0_nxt.d     = q_item.mag_b;
    s0_nxt.num   = {q_item.mag_a, {fxa_pkg::FracW{1'b0}}};
    s0_nxt.pll = W'(q_item.mag_a[HW-1:0]) * W'(q_item.mag_b[HW-1:0]);
    s0_nxt.plh = W'(q_item.mag_a[HW-1:0]) * W'(q_item.mag_b[W-1:HW]);
    s0_nxt.phl = W'(q_item.mag_a[W-1:HW]) * W'(q_item.mag_b[HW-1:0]);
    s0_nxt.phh = W'(q_item.mag_a[W-1:HW]) * W'(q_item.mag_b[W-1:HW]);
    unique case (q_item.op)
      fxa_pkg::OP_ADD:     s0_nxt.simple.result = a + b;
      fxa_pkg::OP_SUB:     s0_nxt.simple.result = a - b;
      fxa_pkg::OP_GT:      s0_nxt.simple.flag = lt_ba;
      fxa_pkg::OP_LT:      s0_nxt.simple.flag = lt_ab;
      fxa_pkg::OP_GE:      s0_nxt.simple.flag = !lt_ab;
      fxa_pkg::OP_LE:      s0_nxt.simple.flag = !lt_ba;
      fxa_pkg::OP_EQ:      s0_nxt.simple.flag = (a == b);
      fxa_pkg::OP_NE:      s0_nxt.simple.flag = (a != b);
      fxa_pkg::OP_MIN:     s0_nxt.simple.result = lt_ba ? b : a;
      fxa_pkg::OP_MAX:     s0_nxt.simple.result = lt_ba ? a : b;
      fxa_pkg::OP_INC:     s0_nxt.simple.result = a + W'(1);
      fxa_pkg::OP_DEC:     s0_nxt.simple.result = a - W'(1);
      fxa_pkg::OP_TOINT: begin
        s0_nxt.simple.result = a[W-1] ? -(q_item.mag_a >> fxa_pkg::FracW)
                                      : (q_item.mag_a >> fxa_pkg::FracW);
      end
      fxa_pkg::OP_FROMINT: s0_nxt.simple.result = a << fxa_pkg::FracW;
      default:             s0_nxt.simple = '0;
    endcase
    if (q_item.is_div && q_item.div_zero) s0_nxt.simple.status = 1'b1;
  end

  // stages 1..NS: stage 1 sums the product, every stage does one divide step
  always_comb begin
    logic [W:0] trial;
    sn_nxt[0] = s0_nxt;
    for (int i = 1; i <= NS; i++) begin
      sn_nxt[i] = st_r[i-1];
      if (i == 1) begin
        sn_nxt[i].prod = {st_r[0].phh, st_r[0].pll}
                       + {{HW{1'b0}}, st_r[0].plh, {HW{1'b0}}}
                       + {{HW{1'b0}}, st_r[0].phl, {HW{1'b0}}};
      end
      trial = {st_r[i-1].rem[W-1:0], st_r[i-1].num[NS-1]};
      sn_nxt[i].num = st_r[i-1].num << 1;
      if (trial >= {1'b0, st_r[i-1].d}) begin
        sn_nxt[i].rem = trial - {1'b0, st_r[i-1].d};
        sn_nxt[i].quo = {st_r[i-1].quo[NS-2:0], 1'b1};
      end else begin
        sn_nxt[i].rem = trial;
        sn_nxt[i].quo = {st_r[i-1].quo[NS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NS; i++) st_r[i].valid <= 1'b0;
    end else if (adv) begin
      for (int i = 0; i <= NS; i++) st_r[i] <= sn_nxt[i];
    end
  end

  // final selection with sign applied
  always_comb begin
    logic [W-1:0] m;
    m = '0;
    out_res = st_r[NS].simple;
    if (st_r[NS].op == fxa_pkg::OP_MUL) begin
      m = st_r[NS].prod[W+fxa_pkg::FracW-1:fxa_pkg::FracW];
      out_res.result = st_r[NS].neg ? -m : m;
    end else if (st_r[NS].op == fxa_pkg::OP_DIV && !st_r[NS].dz) begin
      m = st_r[NS].quo[W-1:0];
      out_res.result = st_r[NS].neg ? -m : m;
    end
  end

endmodule

/* sv/fixed_point_q24_8_alu_top.sv */
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_top
// Signed Q24.8 fixed-point ALU: front stage, queue, execution pipeline.
// ----------------------------------------------------------------------------
// channel  | handshake             | payload
// in       | in_valid / in_ready   | in_req_type, in_operand_a, in_operand_b
// out      | out_valid / out_ready | out_result, out_flag, out_status
//
// One request per cycle sustained while out_ready is high. An accepted
// request passes the front register, one queue slot, then 41 pipeline
// registers (stage 0 plus 40 divide steps), which every operation
// traverses so results leave in order.
// Reset (rst_n low, synchronous) empties the front, queue and pipeline.
// An out_ready stall freezes the pipeline; the queue absorbs the front.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [3:0]                       in_req_type,
  input  logic signed [fxa_pkg::WordW-1:0] in_operand_a,
  input  logic signed [fxa_pkg::WordW-1:0] in_operand_b,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [fxa_pkg::WordW-1:0] out_result,
  output logic                             out_flag,
  output logic                             out_status
);

  logic           f_valid, f_ready, b_valid, b_ready;
  fxa_pkg::item_t f_item, b_item;
  fxa_pkg::res_t  res;

  fxa_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_operand_a, .in_operand_b,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  fxa_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_item(b_item)
  );

  fxa_back u_back (
    .clk, .rst_n, .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_result = res.result;
  assign out_flag   = res.flag;
  assign out_status = res.status;

endmodule
